FILE: rtl/core/llat_pkg.sv
// Package with types, constants and the next-generation row function for the automaton core.
`timescale 1ns / 1ps
package llat_pkg;

  localparam int MaxCols  = 64;
  localparam int MaxRows  = 64;
  localparam int ColAw    = $clog2(MaxCols);
  localparam int RowAw    = $clog2(MaxRows);
  localparam int SizeW    = 7;
  localparam int MaskW    = 9;
  localparam int NbrMax   = 8;
  localparam int CntW     = $clog2(NbrMax + 1);
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam logic [MaskW-1:0] BirthReset = MaskW'(8);
  localparam logic [MaskW-1:0] SurvReset  = MaskW'(12);
  localparam logic [SizeW-1:0] ColsReset  = SizeW'(64);
  localparam logic [SizeW-1:0] RowsReset  = SizeW'(64);

  typedef enum logic [1:0] {
    ActWrite   = 2'd0,
    ActRead    = 2'd1,
    ActAdvance = 2'd2,
    ActClear   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBirth = 2'd0,
    CfgSurv  = 2'd1,
    CfgCols  = 2'd2,
    CfgRows  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StCell,
    StGenFirst,
    StGenSecond,
    StGenStep,
    StGenLast
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OpNop,
    OpCapture,
    OpCellDone,
    OpClear,
    OpGenStart,
    OpGenFirst,
    OpGenSecond,
    OpGenStep,
    OpGenLast
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic single_row;
    logic next_last;
  } dp_status_t;

  // Computes the next generation of one row from its rows above and below.
  function automatic logic [MaxCols-1:0] life_next_row(
    input logic [MaxCols-1:0] above,
    input logic [MaxCols-1:0] cur,
    input logic [MaxCols-1:0] below,
    input logic [ColAw-1:0]   nc_m1,
    input logic [MaskW-1:0]   birth,
    input logic [MaskW-1:0]   surv
  );
    logic [MaxCols-1:0] nxt;
    logic [ColAw-1:0]   li;
    logic [ColAw-1:0]   ri;
    logic [CntW-1:0]    cnt;
    logic [MaskW-1:0]   m;
    nxt = cur;
    for (int c = 0; c < MaxCols; c++) begin
      li  = (c == 0) ? nc_m1 : ColAw'(c - 1);
      ri  = (ColAw'(c) == nc_m1) ? '0 : ColAw'(c + 1);
      cnt = CntW'(above[li]) + CntW'(above[c]) + CntW'(above[ri])
          + CntW'(cur[li]) + CntW'(cur[ri])
          + CntW'(below[li]) + CntW'(below[c]) + CntW'(below[ri]);
      m   = cur[c] ? surv : birth;
      if (ColAw'(c) <= nc_m1) begin
        nxt[c] = m[cnt];
      end
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/core/llat_if.sv
// Handshake interfaces for the action items and the result items.
`timescale 1ns / 1ps
interface llat_item_if import llat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [ColAw-1:0] cell_col;
  logic [RowAw-1:0] cell_row;
  logic             cell_value;

  modport source (output valid, action, cell_col, cell_row, cell_value, input ready);
  modport sink (input valid, action, cell_col, cell_row, cell_value, output ready);
endinterface

interface llat_result_if ();
  logic valid;
  logic ready;
  logic read_value;
  logic out_of_range;

  modport source (output valid, read_value, out_of_range, input ready);
  modport sink (input valid, read_value, out_of_range, output ready);
endinterface

FILE: rtl/core/llat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module llat_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/llat_ctrl.sv
// Controller state machine that sequences cell accesses, clears and generation steps.
`timescale 1ns / 1ps
module llat_ctrl import llat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  action_e     act;

  assign act        = action_e'(action_i);
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (act)
            ActWrite, ActRead: state_d = StCell;
            ActAdvance:        state_d = StGenFirst;
            ActClear:          state_d = StIdle;
            default:           state_d = StIdle;
          endcase
        end
      end
      StCell:      state_d = StIdle;
      StGenFirst:  state_d = StGenSecond;
      StGenSecond: state_d = status_i.single_row ? StGenLast : StGenStep;
      StGenStep:   state_d = status_i.next_last ? StGenLast : StGenStep;
      StGenLast:   state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o.op = OpNop;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (act)
            ActWrite, ActRead: cmd_o.op = OpCapture;
            ActAdvance:        cmd_o.op = OpGenStart;
            ActClear:          cmd_o.op = OpClear;
            default:           cmd_o.op = OpNop;
          endcase
        end
      end
      StCell:      cmd_o.op = OpCellDone;
      StGenFirst:  cmd_o.op = OpGenFirst;
      StGenSecond: cmd_o.op = OpGenSecond;
      StGenStep:   cmd_o.op = OpGenStep;
      StGenLast:   cmd_o.op = OpGenLast;
      default:     cmd_o.op = OpNop;
    endcase
    cmd_o.res_load = (cmd_o.op == OpCellDone) || (cmd_o.op == OpClear)
                  || (cmd_o.op == OpGenLast);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/llat_dp.sv
// Datapath with the grid memory, row window, rule logic, settings and result registers.
`timescale 1ns / 1ps
module llat_dp import llat_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic [1:0]          action_i,
  input  logic [ColAw-1:0]    cell_col_i,
  input  logic [RowAw-1:0]    cell_row_i,
  input  logic                cell_value_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                read_value_o,
  output logic                out_of_range_o
);

  logic [MaskW-1:0]   birth_q, surv_q;
  logic [SizeW-1:0]   cols_q, rows_q;
  logic [SizeW-1:0]   nc_act, nr_act;
  logic [ColAw-1:0]   nc_m1;
  logic [RowAw-1:0]   nr_m1;

  logic [ColAw-1:0]   col_q;
  logic [RowAw-1:0]   row_q;
  logic               val_q;
  logic               wr_q;

  logic [MaxCols-1:0] first_q, prior_q, cur_q;
  logic [RowAw-1:0]   wr_row_q;

  logic [MaxRows-1:0] row_valid_q;
  logic               rd_vld_q;
  logic [MaxCols-1:0] ram_rdata, row_word;
  logic               ram_re, ram_we;
  logic [RowAw-1:0]   ram_raddr, ram_waddr;
  logic [MaxCols-1:0] ram_wdata;
  logic [MaxCols-1:0] next_row, cell_word, one_hot;
  logic               in_range;
  logic               read_value_q, out_of_range_q;

  always_comb begin
    priority if (cols_q == '0) begin
      nc_act = SizeW'(1);
    end else if (cols_q > SizeW'(MaxCols)) begin
      nc_act = SizeW'(MaxCols);
    end else begin
      nc_act = cols_q;
    end
    priority if (rows_q == '0) begin
      nr_act = SizeW'(1);
    end else if (rows_q > SizeW'(MaxRows)) begin
      nr_act = SizeW'(MaxRows);
    end else begin
      nr_act = rows_q;
    end
  end

  assign nc_m1 = ColAw'(nc_act - SizeW'(1));
  assign nr_m1 = RowAw'(nr_act - SizeW'(1));

  assign status_o.single_row = (nr_m1 == '0);
  assign status_o.next_last  = ((wr_row_q + RowAw'(1)) == nr_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q <= BirthReset;
      surv_q  <= SurvReset;
      cols_q  <= ColsReset;
      rows_q  <= RowsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBirth: birth_q <= cfg_wdata_i[MaskW-1:0];
        CfgSurv:  surv_q  <= cfg_wdata_i[MaskW-1:0];
        CfgCols:  cols_q  <= cfg_wdata_i[SizeW-1:0];
        CfgRows:  rows_q  <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // A row that was never written since reset or the last clear reads as all dead.
  assign row_word = rd_vld_q ? ram_rdata : '0;

  assign in_range = ({1'b0, col_q} < nc_act) && ({1'b0, row_q} < nr_act);
  assign one_hot  = MaxCols'(1) << col_q;
  assign cell_word = val_q ? (row_word | one_hot) : (row_word & ~one_hot);

  assign next_row = life_next_row(prior_q, cur_q,
                                  (cmd_i.op == OpGenLast) ? first_q : row_word,
                                  nc_m1, birth_q, surv_q);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (cmd_i.op)
      OpCapture: begin
        ram_re    = 1'b1;
        ram_raddr = cell_row_i;
      end
      OpGenStart: begin
        ram_re    = 1'b1;
        ram_raddr = nr_m1;
      end
      OpGenFirst: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      OpGenSecond: begin
        ram_re    = 1'b1;
        ram_raddr = RowAw'(1);
      end
      OpGenStep: begin
        ram_re    = 1'b1;
        ram_raddr = wr_row_q + RowAw'(2);
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_row_q;
    ram_wdata = next_row;
    unique case (cmd_i.op)
      OpCellDone: begin
        ram_we    = wr_q && in_range;
        ram_waddr = row_q;
        ram_wdata = cell_word;
      end
      OpGenStep, OpGenLast: ram_we = 1'b1;
      default: ;
    endcase
  end

  llat_ram #(
    .Width(MaxCols),
    .Depth(MaxRows)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_vld_q <= row_valid_q[ram_raddr];
      end
      if (cmd_i.op == OpClear) begin
        row_valid_q <= '0;
      end else if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpCapture: begin
        col_q <= cell_col_i;
        row_q <= cell_row_i;
        val_q <= cell_value_i;
        wr_q  <= (action_e'(action_i) == ActWrite);
      end
      OpGenFirst: prior_q <= row_word;
      OpGenSecond: begin
        cur_q    <= row_word;
        first_q  <= row_word;
        wr_row_q <= '0;
      end
      OpGenStep: begin
        prior_q  <= cur_q;
        cur_q    <= row_word;
        wr_row_q <= wr_row_q + RowAw'(1);
      end
      default: ;
    endcase
    if (cmd_i.res_load) begin
      if (cmd_i.op == OpCellDone) begin
        read_value_q   <= !wr_q && in_range && row_word[col_q];
        out_of_range_q <= !in_range;
      end else begin
        read_value_q   <= 1'b0;
        out_of_range_q <= 1'b0;
      end
    end
  end

  assign read_value_o   = read_value_q;
  assign out_of_range_o = out_of_range_q;

endmodule

FILE: rtl/core/life_like_automaton_torus_core.sv
// Top level of the toroidal life-like cellular automaton core.
//
//   Channel   Dir  Handshake       Payload
//   item_i    in   valid / ready   action, cell_col, cell_row, cell_value
//   result_o  out  valid / ready   read_value, out_of_range
//   cfg       in   cfg_we_i        cfg_idx_i, cfg_wdata_i
//
// One item is worked on at a time; a waiting result holds off the next item
// until the cycle in which that result is taken.
// Cell write or read: done in StCell, after the registered read of the grid RAM.
// Clear: done as the item is taken. Advance: one row per cycle through the
// single read and single write port of the grid memory.
// Reset is asynchronous; it kills every cell through per-row valid bits at once.
`timescale 1ns / 1ps
module life_like_automaton_torus_core import llat_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  llat_item_if.sink           item_i,
  llat_result_if.source       result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  llat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .action_i   (item_i.action),
    .in_ready_o (in_ready),
    .out_ready_i(result_o.ready),
    .out_valid_o(out_valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  llat_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .action_i      (item_i.action),
    .cell_col_i    (item_i.cell_col),
    .cell_row_i    (item_i.cell_row),
    .cell_value_i  (item_i.cell_value),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .read_value_o  (result_o.read_value),
    .out_of_range_o(result_o.out_of_range)
  );

  assign item_i.ready   = in_ready;
  assign result_o.valid = out_valid;

  logic item_fire;
  assign item_fire = item_i.valid && in_ready;

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_fire && (item_i.action == ActClear)
    |=> out_valid && !result_o.read_value && !result_o.out_of_range)
    else $error("clear item did not give an all-zero result");

  a_gen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_fire && (item_i.action == ActAdvance) |=> !in_ready ##1 !in_ready)
    else $error("item accepted during a generation step");

  a_gen_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OpGenLast) |=> out_valid && !result_o.out_of_range)
    else $error("generation step ended without a result");

  a_load_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OpCellDone) |-> !in_ready)
    else $error("item taken while a cell access is still open");

endmodule
